@@ hdl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/led_pkg.sv @@
package led_pkg;

  localparam int SYM_W        = 8;
  localparam int MODE_W       = 2;
  localparam int DIST_W       = 6;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIST   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic app_first;
    logic app_second;
    logic take_empty;
    logic init_start;
    logic init_step;
    logic row_start;
    logic cell_step;
    logic launch;
  } led_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic last_col;
    logic last_row;
  } led_sts_t;

endpackage

@@ hdl/led_dpath.sv @@
module led_dpath #(
  parameter int MAX_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  led_pkg::led_cmd_t              cmd,
  input  logic [led_pkg::SYM_W-1:0]      symbol,
  output led_pkg::led_sts_t              sts,
  output logic [led_pkg::DIST_W-1:0]     distance,
  output logic                           overflow
);
  import led_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = (CW > DIST_W) ? CW : DIST_W;

  logic [SYM_W-1:0] first_mem  [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [CW-1:0]    cost_mem   [MAX_LEN+1];

  logic [CW-1:0]    n1;
  logic [CW-1:0]    n2;
  logic             truncated;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    im1;
  logic [CW-1:0]    jp1;
  logic [CW-1:0]    left;
  logic [CW-1:0]    diag;
  logic [CW-1:0]    above;
  logic [CW-1:0]    result;
  logic [SYM_W-1:0] a_sym;
  logic [SYM_W-1:0] b_sym;
  logic [CW:0]      up_cost;
  logic [CW:0]      left_cost;
  logic [CW:0]      diag_cost;
  logic [CW:0]      min_ab;
  logic [CW:0]      min_all;
  logic [CW-1:0]    cell_cost;
  logic [DW-1:0]    dist_ext;
  logic             b_rd;
  logic [AW-1:0]    b_addr;
  logic [CW-1:0]    c_addr;

  assign im1 = i - 1'b1;
  assign jp1 = j + 1'b1;

  assign sts.empty    = (n1 == '0) || (n2 == '0);
  assign sts.last_col = (j == n2);
  assign sts.last_row = (i == n1);

  // Cell update: min of above+1, left+1, diag+mismatch.
  assign up_cost   = {1'b0, above} + 1'b1;
  assign left_cost = {1'b0, left} + 1'b1;
  assign diag_cost = {1'b0, diag} + ((a_sym != b_sym) ? 1'b1 : 1'b0);
  assign min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
  assign min_all   = (min_ab < diag_cost) ? min_ab : diag_cost;
  assign cell_cost = min_all[CW-1:0];

  assign dist_ext = DW'(result);

  // Prefetch the next column while the current cell is written.
  assign b_rd   = cmd.row_start || (cmd.cell_step && !sts.last_col);
  assign b_addr = cmd.row_start ? '0 : j[AW-1:0];
  assign c_addr = cmd.row_start ? CW'(1) : jp1;

  always_ff @(posedge clk) begin
    if (cmd.app_first && (n1 < CW'(MAX_LEN))) begin
      first_mem[n1[AW-1:0]] <= symbol;
    end
    if (cmd.app_second && (n2 < CW'(MAX_LEN))) begin
      second_mem[n2[AW-1:0]] <= symbol;
    end
    if (cmd.row_start) begin
      a_sym <= first_mem[im1[AW-1:0]];
    end
    if (b_rd) begin
      b_sym <= second_mem[b_addr];
      above <= cost_mem[c_addr];
    end
    if (cmd.init_step) begin
      cost_mem[j] <= j;
    end else if (cmd.cell_step) begin
      cost_mem[j] <= cell_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      i <= CW'(1);
      j <= CW'(1);
    end else if (cmd.init_step) begin
      j <= jp1;
    end else if (cmd.row_start) begin
      j    <= CW'(1);
      diag <= im1;
      left <= i;
    end else if (cmd.cell_step) begin
      left   <= cell_cost;
      diag   <= above;
      result <= cell_cost;
      if (sts.last_col) begin
        i <= i + 1'b1;
      end else begin
        j <= jp1;
      end
    end else if (cmd.take_empty) begin
      result <= n1 | n2;
    end
    if (cmd.launch) begin
      distance <= dist_ext[DIST_W-1:0];
      overflow <= truncated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1        <= '0;
      n2        <= '0;
      truncated <= 1'b0;
    end else if (cmd.launch) begin
      n1        <= '0;
      n2        <= '0;
      truncated <= 1'b0;
    end else begin
      if (cmd.app_first) begin
        if (n1 < CW'(MAX_LEN)) begin
          n1 <= n1 + 1'b1;
        end else begin
          truncated <= 1'b1;
        end
      end
      if (cmd.app_second) begin
        if (n2 < CW'(MAX_LEN)) begin
          n2 <= n2 + 1'b1;
        end else begin
          truncated <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/led_ctrl.sv @@
module led_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [led_pkg::MODE_W-1:0]  mode,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  led_pkg::led_sts_t           sts,
  output led_pkg::led_cmd_t           cmd
);
  import led_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_ROW  = 5'b00100,
    ST_CELL = 5'b01000,
    ST_HOLD = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_FIRST:  cmd.app_first  = 1'b1;
            MODE_SECOND: cmd.app_second = 1'b1;
            MODE_DIST: begin
              if (sts.empty) begin
                cmd.take_empty = 1'b1;
                state_next     = ST_HOLD;
              end else begin
                cmd.init_start = 1'b1;
                state_next     = ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.last_col) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_start = 1'b1;
        state_next    = ST_CELL;
      end
      ST_CELL: begin
        cmd.cell_step = 1'b1;
        if (sts.last_col) begin
          state_next = sts.last_row ? ST_HOLD : ST_ROW;
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.launch = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.launch) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/levenshtein_edit_distance.sv @@
// Append beats (mode 0 and 1) are taken one per cycle while the controller is idle.
// A distance beat with both strings non-empty returns its result after a sweep of
// the single cost-row memory, one matrix cell per cycle; if a string is empty, the
// sweep is skipped.
// No new beat is taken during the sweep. Synchronous reset clears counts,
// overflow flag, controller state and output valid; memories keep contents.
`include "assert_macros.svh"

module levenshtein_edit_distance #(
  parameter int MAX_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] distance, [7:6] zero
  output logic [0:0] m_axis_tuser    // [0] overflow
);
  import led_pkg::*;

  led_cmd_t          cmd;
  led_sts_t          sts;
  logic [DIST_W-1:0] distance;
  logic              overflow;
  logic [3:0]        sweep_cmd;
  logic              busy_cmd;
  logic [DIST_W-1:0] out_dist;

  led_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .mode      (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  led_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .symbol   (s_axis_tdata),
    .sts      (sts),
    .distance (distance),
    .overflow (overflow)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-DIST_W){1'b0}}, distance};
  assign m_axis_tuser = overflow;

  assign sweep_cmd = {cmd.init_step, cmd.row_start, cmd.cell_step, cmd.launch};
  assign busy_cmd  = cmd.cell_step || cmd.init_step || cmd.row_start;
  assign out_dist  = m_axis_tdata[DIST_W-1:0];

  `ASSERT_NEXT(a_launch_valid, cmd.launch, m_axis_tvalid, "result launch did not raise valid")
  `ASSERT_CLK(a_cmd_excl, $onehot0(sweep_cmd), "sweep commands overlap")
  `ASSERT_IMPLY(a_no_accept_busy, s_axis_tready, !busy_cmd, "input accepted during sweep")
  `ASSERT_IMPLY(a_dist_range, m_axis_tvalid, int'(out_dist) <= MAX_LEN, "distance above limit")

endmodule
